// File: src/tie_pkg.sv
package tie_pkg;

  localparam int NUM_REGS_DEF  = 16;
  localparam int MEM_BYTES_DEF = 65536;

  localparam int KIND_W  = 6;
  localparam int FAULT_W = 3;

  localparam logic [KIND_W-1:0] KIND_NOP      = 6'd0;
  localparam logic [KIND_W-1:0] KIND_MOV_RI8  = 6'd1;
  localparam logic [KIND_W-1:0] KIND_MOV_RI16 = 6'd2;
  localparam logic [KIND_W-1:0] KIND_MOV_RI32 = 6'd3;
  localparam logic [KIND_W-1:0] KIND_MOV_RM8  = 6'd4;
  localparam logic [KIND_W-1:0] KIND_MOV_RR   = 6'd5;
  localparam logic [KIND_W-1:0] KIND_MOV_MI8  = 6'd6;
  localparam logic [KIND_W-1:0] KIND_MOV_MI16 = 6'd7;
  localparam logic [KIND_W-1:0] KIND_MOV_MI32 = 6'd8;
  localparam logic [KIND_W-1:0] KIND_MOV_MM8  = 6'd9;
  localparam logic [KIND_W-1:0] KIND_MOV_MR32 = 6'd10;
  localparam logic [KIND_W-1:0] KIND_MOV_IND  = 6'd11;
  localparam logic [KIND_W-1:0] KIND_STI8     = 6'd12;
  localparam logic [KIND_W-1:0] KIND_STI16    = 6'd13;
  localparam logic [KIND_W-1:0] KIND_STI32    = 6'd14;
  localparam logic [KIND_W-1:0] KIND_JMP_REL  = 6'd15;
  localparam logic [KIND_W-1:0] KIND_JMP_ABS  = 6'd16;
  localparam logic [KIND_W-1:0] KIND_JMP_REG  = 6'd17;
  localparam logic [KIND_W-1:0] KIND_JNE      = 6'd18;
  localparam logic [KIND_W-1:0] KIND_CMP      = 6'd19;
  localparam logic [KIND_W-1:0] KIND_INC      = 6'd20;
  localparam logic [KIND_W-1:0] KIND_DEC      = 6'd21;
  localparam logic [KIND_W-1:0] KIND_HALT     = 6'd22;
  localparam logic [KIND_W-1:0] KIND_ADD_RR   = 6'd23;
  localparam logic [KIND_W-1:0] KIND_ADD_RI   = 6'd24;
  localparam logic [KIND_W-1:0] KIND_SUB_RR   = 6'd25;
  localparam logic [KIND_W-1:0] KIND_SUB_RI   = 6'd26;
  localparam logic [KIND_W-1:0] KIND_SUB_IR   = 6'd27;
  localparam logic [KIND_W-1:0] KIND_MUL_RR   = 6'd28;
  localparam logic [KIND_W-1:0] KIND_MUL_RI   = 6'd29;
  localparam logic [KIND_W-1:0] KIND_DIV_RR   = 6'd30;
  localparam logic [KIND_W-1:0] KIND_DIV_RI   = 6'd31;
  localparam logic [KIND_W-1:0] KIND_DIV_IR   = 6'd32;

  localparam logic [FAULT_W-1:0] FAULT_NONE = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_REG  = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_ADDR = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_DIV  = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_OP   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        reg_a;
    logic [7:0]        reg_b;
    logic [7:0]        reg_dest;
    logic [31:0]       immediate;
    logic [31:0]       addr_dest;
    logic [31:0]       addr_src;
    logic [31:0]       next_ip;
  } in_item_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_code;
    logic               stopped;
    logic               jump_taken;
    logic [31:0]        jump_target;
    logic               reg_write_en;
    logic [7:0]         reg_write_index;
    logic [31:0]        reg_write_value;
  } out_item_t;

endpackage

// File: src/tie_if.sv
interface tie_in_if;
  logic                      valid;
  logic                      ready;
  logic [tie_pkg::KIND_W-1:0] kind;
  logic [7:0]                reg_a;
  logic [7:0]                reg_b;
  logic [7:0]                reg_dest;
  logic [31:0]               immediate;
  logic [31:0]               addr_dest;
  logic [31:0]               addr_src;
  logic [31:0]               next_ip;

  modport source (output valid, kind, reg_a, reg_b, reg_dest, immediate, addr_dest,
                  addr_src, next_ip, input ready);
  modport sink (input valid, kind, reg_a, reg_b, reg_dest, immediate, addr_dest,
                addr_src, next_ip, output ready);
endinterface

interface tie_out_if;
  logic                        valid;
  logic                        ready;
  logic [tie_pkg::FAULT_W-1:0] fault_code;
  logic                        stopped;
  logic                        jump_taken;
  logic [31:0]                 jump_target;
  logic                        reg_write_en;
  logic [7:0]                  reg_write_index;
  logic [31:0]                 reg_write_value;

  modport source (output valid, fault_code, stopped, jump_taken, jump_target,
                  reg_write_en, reg_write_index, reg_write_value, input ready);
  modport sink (input valid, fault_code, stopped, jump_taken, jump_target,
                reg_write_en, reg_write_index, reg_write_value, output ready);
endinterface

// File: src/tie_regfile.sv
module tie_regfile #(
  parameter int NUM_REGS = tie_pkg::NUM_REGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [$clog2(NUM_REGS)-1:0] rd_a_addr,
  input  logic [$clog2(NUM_REGS)-1:0] rd_b_addr,
  output logic [31:0]                 rd_a_data,
  output logic [31:0]                 rd_b_data,
  input  logic                        wr_en,
  input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
  input  logic [31:0]                 wr_data
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [31:0]         q_a_r;
  logic [31:0]         q_b_r;
  logic                q_a_vld_r;
  logic                q_b_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a_r <= mem[rd_a_addr];
    q_b_r <= mem[rd_b_addr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      q_a_vld_r <= 1'b0;
      q_b_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      q_a_vld_r <= vld_r[rd_a_addr];
      q_b_vld_r <= vld_r[rd_b_addr];
    end
  end

  assign rd_a_data = q_a_vld_r ? q_a_r : 32'd0;
  assign rd_b_data = q_b_vld_r ? q_b_r : 32'd0;

endmodule

// File: src/tie_bytemem.sv
module tie_bytemem #(
  parameter int MEM_BYTES = tie_pkg::MEM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         clr_busy,
  input  logic [$clog2(MEM_BYTES)-1:0] rd_addr,
  output logic [7:0]                   rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MEM_BYTES)-1:0] wr_addr,
  input  logic [7:0]                   wr_data
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]    mem [MEM_BYTES];
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  // zero sweep after reset, one byte a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MEM_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 8'd0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign clr_busy = clr_busy_r;

endmodule

// File: src/tie_divider.sv
module tie_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] trial;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: src/toy_isa_instruction_executor_core.sv
// Executes one decoded instruction per transfer on in_ch and returns one result on out_ch.
// Items are handled one at a time. After the accepting edge an item passes through register
// read, execute and write back before its result is registered in the output register; as
// needed, a byte load, a multiply, a divide (32-step serial divider) and a store of 1, 2 or
// 4 bytes, one byte at a time through the single write port of the byte memory, come
// between execute and write back. A stopped block goes from idle straight to write back.
// A new item is accepted while the previous result still waits in the output register. After
// reset the byte memory is swept to zero, byte by byte, during which no item is accepted.
module toy_isa_instruction_executor_core #(
  parameter int NUM_REGS  = tie_pkg::NUM_REGS_DEF,
  parameter int MEM_BYTES = tie_pkg::MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tie_in_if.sink    in_ch,
  tie_out_if.source out_ch
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RDREG = 9'b000000100,
    ST_EXEC  = 9'b000001000,
    ST_LOAD  = 9'b000010000,
    ST_MUL   = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_STORE = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  tie_pkg::in_item_t           item_r, item_nxt;
  tie_pkg::out_item_t          out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        equal_r, equal_nxt;
  logic                        stop_r, stop_nxt;
  logic [tie_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic                        halt_r, halt_nxt;
  logic                        wen_r, wen_nxt;
  logic [7:0]                  widx_r, widx_nxt;
  logic [31:0]                 wval_r, wval_nxt;
  logic                        jmp_r, jmp_nxt;
  logic [31:0]                 tgt_r, tgt_nxt;
  logic [2:0]                  stlen_r, stlen_nxt;
  logic [AW-1:0]               staddr_r, staddr_nxt;
  logic [31:0]                 stval_r, stval_nxt;

  logic [31:0] va, vb;
  logic        clr_busy;
  logic [7:0]  ld_data;
  logic        div_busy;
  logic [31:0] div_quo;
  logic        mem_wr_en;
  logic        rf_wr_en;

  // execute-stage decode
  logic [tie_pkg::FAULT_W-1:0] ex_fault;
  logic        ex_wen, ex_jmp, ex_ld, ex_mul, ex_div, ex_halt, ex_cmp;
  logic [7:0]  ex_widx;
  logic [31:0] ex_wval, ex_tgt, ex_jt, ex_staddr, ex_stval, ex_ldaddr, ex_dvd, ex_dvs;
  logic [31:0] mul_b;
  logic [2:0]  ex_stlen, len_mi;
  logic        ra_ok, rb_ok, rd_ok;

  function automatic logic span_ok(input logic [31:0] a, input logic [2:0] len);
    span_ok = ({1'b0, a} + 33'(len)) <= 33'(MEM_BYTES);
  endfunction

  function automatic logic reg_ok(input logic [7:0] r);
    reg_ok = {1'b0, r} < 9'(NUM_REGS);
  endfunction

  tie_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_a_addr (item_r.reg_a[RW-1:0]),
    .rd_b_addr (item_r.reg_b[RW-1:0]),
    .rd_a_data (va),
    .rd_b_data (vb),
    .wr_en     (rf_wr_en),
    .wr_addr   (widx_r[RW-1:0]),
    .wr_data   (wval_r)
  );

  tie_bytemem #(.MEM_BYTES(MEM_BYTES)) u_bytemem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .rd_addr  (ex_ldaddr[AW-1:0]),
    .rd_data  (ld_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (staddr_r),
    .wr_data  (stval_r[7:0])
  );

  tie_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_EXEC && ex_fault == tie_pkg::FAULT_NONE && ex_div),
    .dividend (ex_dvd),
    .divisor  (ex_dvs),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign ra_ok = reg_ok(item_r.reg_a);
  assign rb_ok = reg_ok(item_r.reg_b);
  assign rd_ok = reg_ok(item_r.reg_dest);

  always_comb begin
    ex_fault  = tie_pkg::FAULT_NONE;
    ex_wen    = 1'b0;
    ex_wval   = '0;
    ex_widx   = (item_r.kind >= tie_pkg::KIND_ADD_RR) ? item_r.reg_dest : item_r.reg_a;
    ex_jmp    = 1'b0;
    ex_tgt    = '0;
    ex_stlen  = '0;
    ex_staddr = item_r.addr_dest;
    ex_stval  = item_r.immediate;
    ex_ld     = 1'b0;
    ex_ldaddr = item_r.addr_src;
    ex_mul    = 1'b0;
    ex_div    = 1'b0;
    ex_dvd    = va;
    ex_dvs    = vb;
    ex_halt   = 1'b0;
    ex_cmp    = 1'b0;
    len_mi    = 3'd4;
    ex_jt     = item_r.addr_dest;
    if (item_r.kind == tie_pkg::KIND_JMP_REL) begin
      ex_jt = item_r.next_ip + item_r.immediate;
    end else if (item_r.kind == tie_pkg::KIND_JMP_REG) begin
      ex_jt = va;
    end
    if (item_r.kind == tie_pkg::KIND_MOV_MI8 || item_r.kind == tie_pkg::KIND_STI8) begin
      len_mi = 3'd1;
    end else if (item_r.kind == tie_pkg::KIND_MOV_MI16 ||
                 item_r.kind == tie_pkg::KIND_STI16) begin
      len_mi = 3'd2;
    end
    unique case (item_r.kind)
      tie_pkg::KIND_NOP: begin
      end
      tie_pkg::KIND_MOV_RI8, tie_pkg::KIND_MOV_RI16, tie_pkg::KIND_MOV_RI32: begin
        if (!ra_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else begin
          ex_wen = 1'b1;
          if (item_r.kind == tie_pkg::KIND_MOV_RI8) begin
            ex_wval = {24'd0, item_r.immediate[7:0]};
          end else if (item_r.kind == tie_pkg::KIND_MOV_RI16) begin
            ex_wval = {16'd0, item_r.immediate[15:0]};
          end else begin
            ex_wval = item_r.immediate;
          end
        end
      end
      tie_pkg::KIND_MOV_RM8: begin
        if (!ra_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else if (!span_ok(item_r.addr_src, 3'd1)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else begin
          ex_wen = 1'b1;
          ex_ld  = 1'b1;
        end
      end
      tie_pkg::KIND_MOV_RR: begin
        if (!ra_ok || !rb_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else begin
          ex_wen  = 1'b1;
          ex_wval = vb;
        end
      end
      tie_pkg::KIND_MOV_MI8, tie_pkg::KIND_MOV_MI16, tie_pkg::KIND_MOV_MI32: begin
        if (!span_ok(item_r.addr_dest, len_mi)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else begin
          ex_stlen = len_mi;
        end
      end
      tie_pkg::KIND_MOV_MM8: begin
        if (!span_ok(item_r.addr_dest, 3'd1) || !span_ok(item_r.addr_src, 3'd1)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else begin
          ex_ld    = 1'b1;
          ex_stlen = 3'd1;
        end
      end
      tie_pkg::KIND_MOV_MR32: begin
        if (!span_ok(item_r.addr_dest, 3'd4)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else if (!rb_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else begin
          ex_stlen = 3'd4;
          ex_stval = vb;
        end
      end
      tie_pkg::KIND_MOV_IND: begin
        ex_ldaddr = vb;
        if (!ra_ok || !rb_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else if (!span_ok(va, 3'd1) || !span_ok(vb, 3'd1)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else begin
          ex_ld     = 1'b1;
          ex_stlen  = 3'd1;
          ex_staddr = va;
        end
      end
      tie_pkg::KIND_STI8, tie_pkg::KIND_STI16, tie_pkg::KIND_STI32: begin
        if (!ra_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else if (!span_ok(va, len_mi)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else begin
          ex_stlen  = len_mi;
          ex_staddr = va;
        end
      end
      tie_pkg::KIND_JMP_REL, tie_pkg::KIND_JMP_ABS, tie_pkg::KIND_JMP_REG,
      tie_pkg::KIND_JNE: begin
        if (item_r.kind == tie_pkg::KIND_JMP_REG && !ra_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else if (!span_ok(ex_jt, 3'd1)) begin
          ex_fault = tie_pkg::FAULT_ADDR;
        end else begin
          // target is checked even when a not-equal jump falls through
          ex_jmp = (item_r.kind != tie_pkg::KIND_JNE) || !equal_r;
          ex_tgt = ex_jmp ? ex_jt : 32'd0;
        end
      end
      tie_pkg::KIND_CMP: begin
        if (!ra_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else begin
          ex_cmp = 1'b1;
        end
      end
      tie_pkg::KIND_INC, tie_pkg::KIND_DEC: begin
        if (!ra_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else begin
          ex_wen  = 1'b1;
          ex_wval = (item_r.kind == tie_pkg::KIND_INC) ? va + 32'd1 : va - 32'd1;
        end
      end
      tie_pkg::KIND_HALT: begin
        ex_halt = 1'b1;
      end
      tie_pkg::KIND_ADD_RR, tie_pkg::KIND_SUB_RR, tie_pkg::KIND_MUL_RR,
      tie_pkg::KIND_DIV_RR: begin
        if (!ra_ok || !rb_ok || !rd_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else if (item_r.kind == tie_pkg::KIND_DIV_RR && vb == 32'd0) begin
          ex_fault = tie_pkg::FAULT_DIV;
        end else begin
          ex_wen  = 1'b1;
          ex_wval = (item_r.kind == tie_pkg::KIND_ADD_RR) ? va + vb : va - vb;
          ex_mul  = item_r.kind == tie_pkg::KIND_MUL_RR;
          ex_div  = item_r.kind == tie_pkg::KIND_DIV_RR;
        end
      end
      tie_pkg::KIND_ADD_RI, tie_pkg::KIND_SUB_RI, tie_pkg::KIND_SUB_IR,
      tie_pkg::KIND_MUL_RI, tie_pkg::KIND_DIV_RI, tie_pkg::KIND_DIV_IR: begin
        if (item_r.kind == tie_pkg::KIND_DIV_IR) begin
          ex_dvd = item_r.immediate;
          ex_dvs = va;
        end else begin
          ex_dvs = item_r.immediate;
        end
        if (!ra_ok || !rd_ok) begin
          ex_fault = tie_pkg::FAULT_REG;
        end else if ((item_r.kind == tie_pkg::KIND_DIV_RI && item_r.immediate == 32'd0) ||
                     (item_r.kind == tie_pkg::KIND_DIV_IR && va == 32'd0)) begin
          ex_fault = tie_pkg::FAULT_DIV;
        end else begin
          ex_wen = 1'b1;
          if (item_r.kind == tie_pkg::KIND_ADD_RI) begin
            ex_wval = va + item_r.immediate;
          end else if (item_r.kind == tie_pkg::KIND_SUB_RI) begin
            ex_wval = va - item_r.immediate;
          end else begin
            ex_wval = item_r.immediate - va;
          end
          ex_mul = item_r.kind == tie_pkg::KIND_MUL_RI;
          ex_div = item_r.kind == tie_pkg::KIND_DIV_RI || item_r.kind == tie_pkg::KIND_DIV_IR;
        end
      end
      default: begin
        ex_fault = tie_pkg::FAULT_OP;
      end
    endcase
  end

  assign mul_b     = (item_r.kind == tie_pkg::KIND_MUL_RR) ? vb : item_r.immediate;
  assign mem_wr_en = state_r == ST_STORE;
  assign rf_wr_en  = state_r == ST_FIN && (!out_valid_r || out_ch.ready) && wen_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    equal_nxt     = equal_r;
    stop_nxt      = stop_r;
    fault_nxt     = fault_r;
    halt_nxt      = halt_r;
    wen_nxt       = wen_r;
    widx_nxt      = widx_r;
    wval_nxt      = wval_r;
    jmp_nxt       = jmp_r;
    tgt_nxt       = tgt_r;
    stlen_nxt     = stlen_r;
    staddr_nxt    = staddr_r;
    stval_nxt     = stval_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.kind      = in_ch.kind;
          item_nxt.reg_a     = in_ch.reg_a;
          item_nxt.reg_b     = in_ch.reg_b;
          item_nxt.reg_dest  = in_ch.reg_dest;
          item_nxt.immediate = in_ch.immediate;
          item_nxt.addr_dest = in_ch.addr_dest;
          item_nxt.addr_src  = in_ch.addr_src;
          item_nxt.next_ip   = in_ch.next_ip;
          fault_nxt = tie_pkg::FAULT_NONE;
          halt_nxt  = 1'b0;
          wen_nxt   = 1'b0;
          widx_nxt  = '0;
          wval_nxt  = '0;
          jmp_nxt   = 1'b0;
          tgt_nxt   = '0;
          // a stopped block reports and changes nothing
          state_nxt = stop_r ? ST_FIN : ST_RDREG;
        end
      end
      ST_RDREG: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        fault_nxt = ex_fault;
        if (ex_fault != tie_pkg::FAULT_NONE) begin
          state_nxt = ST_FIN;
        end else begin
          halt_nxt   = ex_halt;
          wen_nxt    = ex_wen;
          widx_nxt   = ex_wen ? ex_widx : 8'd0;
          wval_nxt   = ex_wval;
          jmp_nxt    = ex_jmp;
          tgt_nxt    = ex_tgt;
          stlen_nxt  = ex_stlen;
          staddr_nxt = ex_staddr[AW-1:0];
          stval_nxt  = ex_stval;
          if (ex_cmp) begin
            equal_nxt = va == item_r.immediate;
          end
          priority if (ex_ld) begin
            state_nxt = ST_LOAD;
          end else if (ex_mul) begin
            state_nxt = ST_MUL;
          end else if (ex_div) begin
            state_nxt = ST_DIV;
          end else if (ex_stlen != 3'd0) begin
            state_nxt = ST_STORE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_LOAD: begin
        if (item_r.kind == tie_pkg::KIND_MOV_RM8) begin
          wval_nxt  = {24'd0, ld_data};
          state_nxt = ST_FIN;
        end else begin
          stval_nxt = {24'd0, ld_data};
          state_nxt = ST_STORE;
        end
      end
      ST_MUL: begin
        wval_nxt  = 32'(va * mul_b);
        state_nxt = ST_FIN;
      end
      ST_DIV: begin
        if (!div_busy) begin
          wval_nxt  = div_quo;
          state_nxt = ST_FIN;
        end
      end
      ST_STORE: begin
        staddr_nxt = staddr_r + 1'b1;
        stval_nxt  = {8'd0, stval_r[31:8]};
        stlen_nxt  = stlen_r - 1'b1;
        if (stlen_r == 3'd1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.fault_code      = fault_r;
          out_nxt.stopped         = stop_r || halt_r || fault_r != tie_pkg::FAULT_NONE;
          out_nxt.jump_taken      = jmp_r;
          out_nxt.jump_target     = tgt_r;
          out_nxt.reg_write_en    = wen_r;
          out_nxt.reg_write_index = widx_r;
          out_nxt.reg_write_value = wen_r ? wval_r : 32'd0;
          out_valid_nxt           = 1'b1;
          stop_nxt  = stop_r || halt_r || fault_r != tie_pkg::FAULT_NONE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      equal_r     <= 1'b0;
      stop_r      <= 1'b0;
      fault_r     <= tie_pkg::FAULT_NONE;
      halt_r      <= 1'b0;
      wen_r       <= 1'b0;
      jmp_r       <= 1'b0;
      stlen_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      equal_r     <= equal_nxt;
      stop_r      <= stop_nxt;
      fault_r     <= fault_nxt;
      halt_r      <= halt_nxt;
      wen_r       <= wen_nxt;
      jmp_r       <= jmp_nxt;
      stlen_r     <= stlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    widx_r   <= widx_nxt;
    wval_r   <= wval_nxt;
    tgt_r    <= tgt_nxt;
    staddr_r <= staddr_nxt;
    stval_r  <= stval_nxt;
  end

  assign in_ch.ready            = state_r == ST_IDLE;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.fault_code      = out_r.fault_code;
  assign out_ch.stopped         = out_r.stopped;
  assign out_ch.jump_taken      = out_r.jump_taken;
  assign out_ch.jump_target     = out_r.jump_target;
  assign out_ch.reg_write_en    = out_r.reg_write_en;
  assign out_ch.reg_write_index = out_r.reg_write_index;
  assign out_ch.reg_write_value = out_r.reg_write_value;

  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("stop flag cleared while running");

  a_fault_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fault_r != tie_pkg::FAULT_NONE) |-> (!wen_r && !jmp_r))
    else $error("faulting item has side effects");

  a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fault_code != tie_pkg::FAULT_NONE) |-> out_r.stopped)
    else $error("fault reported without stop");

  a_no_write_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en || rf_wr_en) |-> !stop_r)
    else $error("state written while stopped");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_busy) |=> (state_r == ST_DIV))
    else $error("left divide before quotient ready");

endmodule

// File: tb/sv/tb_toy_isa_instruction_executor_core.sv
module tb_toy_isa_instruction_executor_core;
  import tie_pkg::*;

  localparam int NREG  = NUM_REGS_DEF;
  localparam int NMEM  = MEM_BYTES_DEF;
  localparam int IDLE_LIMIT = 200000;  // covers the memory sweep after reset

  class exec_scoreboard;
    logic [31:0] regs [NREG];
    logic [7:0]  mem [int unsigned];
    bit          eq_flag;
    bit          stop_flag;
    out_item_t   pending [$];
    int          errors;
    int          checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      eq_flag = 0;
      stop_flag = 0;
      errors = 0;
      checked = 0;
    endfunction

    function bit reg_ok(logic [7:0] r);
      return r < NREG;
    endfunction

    function bit span_ok(longint unsigned a, int n);
      return a + n <= NMEM;
    endfunction

    function logic [7:0] rd_byte(longint unsigned a);
      if (a >= NMEM || !mem.exists(a)) return 8'h00;
      return mem[a];
    endfunction

    // Computes the outcome of one instruction; state is updated only when commit is set.
    function out_item_t execute(in_item_t it, bit commit);
      out_item_t   o;
      logic [2:0]  f;
      logic [31:0] va, vb, tgt, wv, sv;
      logic [7:0]  wi;
      bit          jmp, wen, eq_n, stop_n;
      int          slen;
      longint unsigned sa;
      o = '0;
      o.stopped = 1'b1;
      if (stop_flag) return o;
      f = FAULT_NONE; jmp = 0; wen = 0; tgt = '0; wv = '0; wi = '0;
      slen = 0; sa = 0; sv = '0; eq_n = eq_flag; stop_n = stop_flag;
      va = reg_ok(it.reg_a) ? regs[it.reg_a[3:0]] : '0;
      vb = reg_ok(it.reg_b) ? regs[it.reg_b[3:0]] : '0;
      case (it.kind)
        KIND_NOP: ;
        KIND_MOV_RI8, KIND_MOV_RI16, KIND_MOV_RI32: begin
          if (!reg_ok(it.reg_a)) f = FAULT_REG;
          else begin
            wen = 1; wi = it.reg_a;
            wv = it.kind == KIND_MOV_RI8 ? {24'h0, it.immediate[7:0]} :
                 it.kind == KIND_MOV_RI16 ? {16'h0, it.immediate[15:0]} : it.immediate;
          end
        end
        KIND_MOV_RM8: begin
          if (!reg_ok(it.reg_a)) f = FAULT_REG;
          else if (!span_ok(it.addr_src, 1)) f = FAULT_ADDR;
          else begin wen = 1; wi = it.reg_a; wv = {24'h0, rd_byte(it.addr_src)}; end
        end
        KIND_MOV_RR: begin
          if (!reg_ok(it.reg_a) || !reg_ok(it.reg_b)) f = FAULT_REG;
          else begin wen = 1; wi = it.reg_a; wv = vb; end
        end
        KIND_MOV_MI8, KIND_MOV_MI16, KIND_MOV_MI32: begin
          slen = it.kind == KIND_MOV_MI8 ? 1 : it.kind == KIND_MOV_MI16 ? 2 : 4;
          if (!span_ok(it.addr_dest, slen)) begin f = FAULT_ADDR; slen = 0; end
          else begin sa = it.addr_dest; sv = it.immediate; end
        end
        KIND_MOV_MM8: begin
          if (!span_ok(it.addr_dest, 1) || !span_ok(it.addr_src, 1)) f = FAULT_ADDR;
          else begin slen = 1; sa = it.addr_dest; sv = {24'h0, rd_byte(it.addr_src)}; end
        end
        KIND_MOV_MR32: begin
          if (!span_ok(it.addr_dest, 4)) f = FAULT_ADDR;
          else if (!reg_ok(it.reg_b)) f = FAULT_REG;
          else begin slen = 4; sa = it.addr_dest; sv = vb; end
        end
        KIND_MOV_IND: begin
          if (!reg_ok(it.reg_a) || !reg_ok(it.reg_b)) f = FAULT_REG;
          else if (!span_ok(va, 1) || !span_ok(vb, 1)) f = FAULT_ADDR;
          else begin slen = 1; sa = va; sv = {24'h0, rd_byte(vb)}; end
        end
        KIND_STI8, KIND_STI16, KIND_STI32: begin
          if (!reg_ok(it.reg_a)) f = FAULT_REG;
          else begin
            slen = it.kind == KIND_STI8 ? 1 : it.kind == KIND_STI16 ? 2 : 4;
            if (!span_ok(va, slen)) begin f = FAULT_ADDR; slen = 0; end
            else begin sa = va; sv = it.immediate; end
          end
        end
        KIND_JMP_REL, KIND_JMP_ABS, KIND_JMP_REG, KIND_JNE: begin
          if (it.kind == KIND_JMP_REL) tgt = it.next_ip + it.immediate;
          else if (it.kind == KIND_JMP_REG) begin
            if (!reg_ok(it.reg_a)) f = FAULT_REG;
            tgt = va;
          end else tgt = it.addr_dest;
          if (f == FAULT_NONE) begin
            if (!span_ok(tgt, 1)) f = FAULT_ADDR;
            else jmp = it.kind != KIND_JNE || !eq_flag;
          end
          if (!jmp) tgt = '0;
        end
        KIND_CMP: begin
          if (!reg_ok(it.reg_a)) f = FAULT_REG;
          else eq_n = va == it.immediate;
        end
        KIND_INC, KIND_DEC: begin
          if (!reg_ok(it.reg_a)) f = FAULT_REG;
          else begin wen = 1; wi = it.reg_a; wv = it.kind == KIND_INC ? va + 1 : va - 1; end
        end
        KIND_HALT: stop_n = 1;
        KIND_ADD_RR, KIND_SUB_RR, KIND_MUL_RR, KIND_DIV_RR: begin
          if (!reg_ok(it.reg_a) || !reg_ok(it.reg_b) || !reg_ok(it.reg_dest)) f = FAULT_REG;
          else if (it.kind == KIND_DIV_RR && vb == 0) f = FAULT_DIV;
          else begin
            wen = 1; wi = it.reg_dest;
            wv = it.kind == KIND_ADD_RR ? va + vb : it.kind == KIND_SUB_RR ? va - vb :
                 it.kind == KIND_MUL_RR ? va * vb : va / vb;
          end
        end
        KIND_ADD_RI, KIND_SUB_RI, KIND_SUB_IR, KIND_MUL_RI, KIND_DIV_RI, KIND_DIV_IR: begin
          if (!reg_ok(it.reg_a) || !reg_ok(it.reg_dest)) f = FAULT_REG;
          else if ((it.kind == KIND_DIV_RI && it.immediate == 0) ||
                   (it.kind == KIND_DIV_IR && va == 0)) f = FAULT_DIV;
          else begin
            wen = 1; wi = it.reg_dest;
            case (it.kind)
              KIND_ADD_RI: wv = va + it.immediate;
              KIND_SUB_RI: wv = va - it.immediate;
              KIND_SUB_IR: wv = it.immediate - va;
              KIND_MUL_RI: wv = va * it.immediate;
              KIND_DIV_RI: wv = va / it.immediate;
              default:     wv = it.immediate / va;
            endcase
          end
        end
        default: f = FAULT_OP;
      endcase
      if (f != FAULT_NONE) begin
        o.fault_code = f;
        if (commit) stop_flag = 1;
        return o;
      end
      if (commit) begin
        for (int i = 0; i < slen; i++) mem[sa + i] = sv[8*i +: 8];
        if (wen) regs[wi[3:0]] = wv;
        eq_flag = eq_n;
        stop_flag = stop_n;
      end
      o.stopped = stop_n;
      o.jump_taken = jmp;
      o.jump_target = tgt;
      o.reg_write_en = wen;
      o.reg_write_index = wen ? wi : '0;
      o.reg_write_value = wen ? wv : '0;
      return o;
    endfunction

    function void note_input(in_item_t it);
      pending.push_back(execute(it, 1));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.fault_code !== exp.fault_code || got.stopped !== exp.stopped ||
          got.jump_taken !== exp.jump_taken || got.jump_target !== exp.jump_target ||
          got.reg_write_en !== exp.reg_write_en ||
          got.reg_write_index !== exp.reg_write_index ||
          got.reg_write_value !== exp.reg_write_value) begin
        errors++;
        if (errors <= 10) $display("result %0d mismatch: expected %p, got %p", checked, exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  tie_in_if  in_if();
  tie_out_if out_if();
  exec_scoreboard sb = new();

  int  n_sent = 0;
  int  idle_cycles = 0;
  bit  hold_done = 0;

  always #10 clk = ~clk;

  toy_isa_instruction_executor_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if)
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // watchdog and result monitor
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_if.valid && out_if.ready)
      sb.check_result(out_item_t'{out_if.fault_code, out_if.stopped, out_if.jump_taken,
        out_if.jump_target, out_if.reg_write_en, out_if.reg_write_index,
        out_if.reg_write_value});
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once traffic is under way
  initial begin
    int g;
    out_if.ready = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_sent >= 300) begin
        hold_done = 1;
        out_if.ready = 0;
        repeat (300) @(negedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_if.ready = 0;
        repeat (g - 1) @(negedge clk);
        @(negedge clk);
      end
      out_if.ready = 1;
    end
  end

  task automatic send(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid = 0;
      repeat (g) @(negedge clk);
    end
    in_if.valid     = 1;
    in_if.kind      = it.kind;
    in_if.reg_a     = it.reg_a;
    in_if.reg_b     = it.reg_b;
    in_if.reg_dest  = it.reg_dest;
    in_if.immediate = it.immediate;
    in_if.addr_dest = it.addr_dest;
    in_if.addr_src  = it.addr_src;
    in_if.next_ip   = it.next_ip;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(it);
    n_sent++;
    @(negedge clk);
  endtask

  function in_item_t mk(logic [5:0] k, logic [7:0] a, logic [7:0] b, logic [7:0] d,
                        logic [31:0] imm, logic [31:0] ad = 0, logic [31:0] as = 0,
                        logic [31:0] nip = 0);
    in_item_t it;
    it = '{k, a, b, d, imm, ad, as, nip};
    return it;
  endfunction

  function logic [7:0] pick_reg();
    return ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, NREG - 1)) : 8'($urandom);
  endfunction

  function logic [31:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 255);
    if (r < 8) return $urandom_range(NMEM - 8, NMEM - 1);
    return $urandom;
  endfunction

  function logic [31:0] pick_imm();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return $urandom_range(0, 300);
    if (r < 8) return 32'h0;
    if (r < 9) return 32'hFFFF_FFFF;
    return $urandom_range(NMEM - 8, NMEM - 1);
  endfunction

  // well-formed instruction: never faults, never halts
  function in_item_t rand_good();
    in_item_t it;
    do begin
      it.kind      = 6'($urandom_range(0, 32));
      it.reg_a     = pick_reg();
      it.reg_b     = pick_reg();
      it.reg_dest  = pick_reg();
      it.immediate = pick_imm();
      it.addr_dest = pick_addr();
      it.addr_src  = pick_addr();
      it.next_ip   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
    end while (it.kind == KIND_HALT || sb.execute(it, 0).fault_code != FAULT_NONE);
    return it;
  endfunction

  initial begin
    in_item_t dir [$];
    in_item_t it;
    int sel;
    in_if.valid = 0;
    in_if.kind = '0; in_if.reg_a = '0; in_if.reg_b = '0; in_if.reg_dest = '0;
    in_if.immediate = '0; in_if.addr_dest = '0; in_if.addr_src = '0; in_if.next_ip = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    dir = '{
      mk(KIND_NOP, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      mk(KIND_MOV_RI8, 0, 0, 0, 32'hFFFF_FFFF),
      mk(KIND_MOV_RI16, 1, 0, 0, 32'h1234_FFFC),
      mk(KIND_MOV_RI32, 15, 0, 0, 32'hFFFF_FFFF),
      mk(KIND_MOV_MI32, 0, 0, 0, 32'hA1B2_C3D4, NMEM - 4),
      mk(KIND_MOV_MI16, 0, 0, 0, 32'h0000_5566, 0),
      mk(KIND_MOV_MI8, 0, 0, 0, 32'h0000_0077, NMEM - 1),
      mk(KIND_MOV_RM8, 2, 0, 0, 0, 0, NMEM - 1),
      mk(KIND_MOV_MM8, 0, 0, 0, 0, 5, NMEM - 2),
      mk(KIND_MOV_RR, 3, 15, 0, 0),
      mk(KIND_MOV_MR32, 0, 15, 0, 0, 16),
      mk(KIND_STI32, 1, 0, 0, 32'hDEAD_BEEF),
      mk(KIND_STI16, 0, 0, 0, 32'hCAFE_F00D),
      mk(KIND_STI8, 1, 0, 0, 32'h0000_0099),
      mk(KIND_MOV_IND, 0, 1, 0, 0),
      mk(KIND_JMP_REL, 0, 0, 0, 32'h0000_0020, 0, 0, 32'hFFFF_FFF0),
      mk(KIND_JMP_ABS, 0, 0, 0, 0, NMEM - 1),
      mk(KIND_JMP_REG, 0, 0, 0, 0),
      mk(KIND_CMP, 0, 0, 0, 32'h0000_00FF),
      mk(KIND_JNE, 0, 0, 0, 0, 100),
      mk(KIND_CMP, 0, 0, 0, 32'h0),
      mk(KIND_JNE, 0, 0, 0, 0, 200),
      mk(KIND_INC, 15, 0, 0, 0),
      mk(KIND_DEC, 15, 0, 0, 0),
      mk(KIND_MUL_RR, 3, 3, 4, 0)
    };
    foreach (dir[i]) send(dir[i]);
    // remaining arithmetic forms once each with nonzero divisors
    send(mk(KIND_MOV_RI32, 5, 0, 0, 32'h8000_0001));
    send(mk(KIND_MOV_RI8, 6, 0, 0, 32'h7));
    send(mk(KIND_ADD_RR, 5, 5, 7, 0));
    send(mk(KIND_ADD_RI, 5, 0, 7, 32'hFFFF_FFFF));
    send(mk(KIND_SUB_RR, 6, 5, 7, 0));
    send(mk(KIND_SUB_RI, 6, 0, 7, 32'h10));
    send(mk(KIND_SUB_IR, 5, 0, 7, 32'h3));
    send(mk(KIND_MUL_RI, 5, 0, 7, 32'hFFFF_FFFF));
    send(mk(KIND_DIV_RR, 5, 6, 7, 0));
    send(mk(KIND_DIV_RI, 5, 0, 7, 32'hFFFF_FFFF));
    send(mk(KIND_DIV_IR, 6, 0, 7, 32'hFFFF_FFFF));

    repeat (800) send(rand_good());

    // one stopping event ends the running state; the rest must be inert
    sel = $urandom_range(0, 4);
    case (sel)
      0: it = mk(KIND_MOV_RR, 8'($urandom_range(NREG, 255)), 0, 0, 0);
      1: it = mk(KIND_MOV_MI32, 0, 0, 0, $urandom, $urandom_range(NMEM - 3, NMEM + 8));
      2: it = mk(KIND_DIV_RI, 0, 0, 1, 0);
      3: it = mk(6'($urandom_range(33, 63)), 0, 0, 0, 0);
      default: it = mk(KIND_HALT, 0, 0, 0, 0);
    endcase
    send(it);
    repeat (5) begin
      it = '{6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             $urandom, $urandom, $urandom, $urandom};
      send(it);
    end
    in_if.valid = 0;

    wait (sb.pending.size() == 0);
    repeat (100) @(posedge clk);
    $display("ran %0d instructions, %0d results checked, all opcodes plus stop case %0d",
             n_sent, sb.checked, sel);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: toy_isa_instruction_executor_core.f
src/tie_pkg.sv
src/tie_if.sv
src/tie_regfile.sv
src/tie_bytemem.sv
src/tie_divider.sv
src/toy_isa_instruction_executor_core.sv
tb/sv/tb_toy_isa_instruction_executor_core.sv
